// ----- rtl/core/stopwatch_with_lap_store_defines.svh -----
// Assertion macros used by the stopwatch port-level checker.
`ifndef STOPWATCH_WITH_LAP_STORE_DEFINES_SVH
`define STOPWATCH_WITH_LAP_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/swls_pkg.sv -----
// Shared types, constants and word formats of the stopwatch with lap store.
package swls_pkg;

    // Field widths of the input and result words.
    localparam int OP_W        = 3;
    localparam int INDEX_W     = 3;
    localparam int RUN_W       = 2;
    localparam int ELAPSED_W   = 40;
    localparam int HELD_W      = 4;
    localparam int LAP_VALUE_W = 40;

    // Default sizing of the block.
    localparam int LAP_DEPTH_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 40;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_START = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET = 3'd3;
    localparam logic [OP_W-1:0] OP_LAP   = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    // Run states of the stopwatch.
    typedef enum logic [RUN_W-1:0] {
        RUN_IDLE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_PAUSED = 2'd2
    } run_state_t;

    // Input word: one operation.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] lap_index;
    } in_word_t;

    // Result word: snapshot after the operation.
    typedef struct packed {
        logic [RUN_W-1:0]       run_state;
        logic [ELAPSED_W-1:0]   elapsed_ticks;
        logic [HELD_W-1:0]      laps_held;
        logic                   lap_taken;
        logic [LAP_VALUE_W-1:0] lap_value;
    } out_word_t;

    // Control from the state logic to the lap memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_hit;
    } mem_ctl_t;

endpackage

// ----- rtl/core/stopwatch_with_lap_store.sv -----
// Stopwatch with lap store: top level with input stage, state logic and result stage.
//
// Each input word is one operation (tick, start, pause, reset, lap or read) and produces
// exactly one result word with the run state, elapsed count, number of stored laps, a
// lap-taken flag and the lap entry selected by lap_index. One word is accepted every
// clock cycle while the result stage is free or its word is being taken. A result word
// becomes valid when its input word moves from the input register into the result
// register. The input register feeds the single update stage, and the update stage
// feeds the result register. Laps live in a LAP_DEPTH-entry ring memory tracked by a
// fill count, so reset needs no clearing pass and the block is ready as soon as reset
// is released. Entries beyond the fill count read as zero. The elapsed count is COUNT_WIDTH
// bits wide and saturates at its maximum; the reported count and lap value are 40 bits.
module stopwatch_with_lap_store #(
    parameter int LAP_DEPTH   = swls_pkg::LAP_DEPTH_DEF,
    parameter int COUNT_WIDTH = swls_pkg::COUNT_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  swls_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output swls_pkg::out_word_t m_data
);

    localparam int AW = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
    localparam int TW = $clog2(LAP_DEPTH + 1);

    logic                                in_vld_reg;
    logic                                in_vld_next;
    swls_pkg::in_word_t                  in_word_reg;
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic                                advance;
    logic                                step;
    logic [swls_pkg::RUN_W-1:0]          run_state_reg;
    logic [swls_pkg::ELAPSED_W-1:0]      elapsed_reg;
    logic [swls_pkg::HELD_W-1:0]         held_reg;
    logic                                taken_reg;
    swls_pkg::mem_ctl_t                  mem_ctl;
    logic [AW-1:0]                       wr_addr;
    logic [COUNT_WIDTH-1:0]              wr_data;
    logic [AW-1:0]                       rd_addr;
    logic [COUNT_WIDTH-1:0]              rd_value;
    swls_pkg::run_state_t                run_state_next;
    logic [COUNT_WIDTH-1:0]              elapsed_next;
    logic [TW-1:0]                       total_next;
    logic                                lap_taken;

    // Handshake: the result stage frees up when empty or when its word is taken.
    assign advance = !m_valid_reg || m_ready;
    assign step    = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (step) begin
            in_vld_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    swls_ctrl #(
        .LAP_DEPTH   (LAP_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW),
        .TW          (TW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .op             (in_word_reg.op),
        .lap_index      (in_word_reg.lap_index),
        .mem_ctl        (mem_ctl),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .run_state_next (run_state_next),
        .elapsed_next   (elapsed_next),
        .total_next     (total_next),
        .lap_taken      (lap_taken)
    );

    swls_lap_mem #(
        .DEPTH (LAP_DEPTH),
        .AW    (AW),
        .DW    (COUNT_WIDTH)
    ) u_lap_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_value (rd_value)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            run_state_reg <= run_state_next;
            elapsed_reg   <= swls_pkg::ELAPSED_W'(elapsed_next);
            held_reg      <= swls_pkg::HELD_W'(total_next);
            taken_reg     <= lap_taken;
        end
    end

    // Result word; the lap value comes from the memory's read register.
    always_comb begin
        m_data.run_state     = run_state_reg;
        m_data.elapsed_ticks = elapsed_reg;
        m_data.laps_held     = held_reg;
        m_data.lap_taken     = taken_reg;
        m_data.lap_value     = swls_pkg::LAP_VALUE_W'(rd_value);
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/swls_lap_mem.sv -----
// Lap memory: circular store with a registered read port and write-to-read forwarding.
module swls_lap_mem #(
    parameter int DEPTH = swls_pkg::LAP_DEPTH_DEF,
    parameter int AW    = 3,
    parameter int DW    = swls_pkg::COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  swls_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      wr_addr,
    input  logic [DW-1:0]      wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [DW-1:0]      rd_value
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] fwd_data_reg;
    logic          fwd_reg;
    logic          hit_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
            fwd_reg      <= ctl.wr_en && (wr_addr == rd_addr);
        end
    end

    // Hit flag: an entry beyond the fill count reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.rd_en) begin
            hit_reg <= ctl.rd_hit;
        end
    end

    always_comb begin
        if (!hit_reg) begin
            rd_value = '0;
        end else if (fwd_reg) begin
            rd_value = fwd_data_reg;
        end else begin
            rd_value = rd_data_reg;
        end
    end

endmodule

// ----- rtl/core/swls_ctrl.sv -----
// Stopwatch state: run state machine, elapsed counter, lap fill count and ring pointer.
module swls_ctrl #(
    parameter int LAP_DEPTH   = swls_pkg::LAP_DEPTH_DEF,
    parameter int COUNT_WIDTH = swls_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = 3,
    parameter int TW          = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [swls_pkg::OP_W-1:0]     op,
    input  logic [swls_pkg::INDEX_W-1:0]  lap_index,
    output swls_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                 wr_addr,
    output logic [COUNT_WIDTH-1:0]        wr_data,
    output logic [AW-1:0]                 rd_addr,
    output swls_pkg::run_state_t          run_state_next,
    output logic [COUNT_WIDTH-1:0]        elapsed_next,
    output logic [TW-1:0]                 total_next,
    output logic                          lap_taken
);

    localparam int SW = AW + 1;
    localparam int ZW = (TW > swls_pkg::INDEX_W) ? TW : swls_pkg::INDEX_W;

    swls_pkg::run_state_t   run_state_reg;
    logic [COUNT_WIDTH-1:0] elapsed_reg;
    logic [TW-1:0]          total_reg;
    logic [AW-1:0]          head_reg;
    logic [AW-1:0]          head_next;
    logic                   is_running;
    logic                   lap_go;
    logic                   count_full;
    logic                   store_full;
    logic [SW-1:0]          rd_sum;

    // Next state of the run state machine.
    always_comb begin
        run_state_next = run_state_reg;
        case (op)
            swls_pkg::OP_START: begin
                run_state_next = swls_pkg::RUN_ACTIVE;
            end
            swls_pkg::OP_PAUSE: begin
                if (run_state_reg == swls_pkg::RUN_ACTIVE) begin
                    run_state_next = swls_pkg::RUN_PAUSED;
                end
            end
            swls_pkg::OP_RESET: begin
                run_state_next = swls_pkg::RUN_IDLE;
            end
            default: begin
            end
        endcase
    end

    // Decoded outputs of the run state machine.
    always_comb begin
        is_running = (run_state_reg == swls_pkg::RUN_ACTIVE);
        lap_go     = is_running && (op == swls_pkg::OP_LAP);
        lap_taken  = lap_go;
    end

    // Counter, fill count and ring pointer updates.
    always_comb begin
        count_full   = &elapsed_reg;
        store_full   = (total_reg == TW'(LAP_DEPTH));
        elapsed_next = elapsed_reg;
        total_next   = total_reg;
        head_next    = head_reg;
        case (op)
            swls_pkg::OP_TICK: begin
                if (is_running && !count_full) begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            swls_pkg::OP_RESET: begin
                elapsed_next = '0;
                total_next   = '0;
                head_next    = '0;
            end
            swls_pkg::OP_LAP: begin
                if (lap_go && !store_full) begin
                    total_next = total_reg + 1'b1;
                end else if (lap_go) begin
                    head_next = (head_reg == AW'(LAP_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                end
            end
            swls_pkg::OP_READ: begin
            end
            default: begin
            end
        endcase
    end

    // The ring only wraps once full, so before that the head stays at zero.
    assign wr_addr = store_full ? head_reg : AW'(total_reg);
    assign wr_data = elapsed_reg;

    // Logical lap index to physical entry, after this operation's update.
    always_comb begin
        rd_sum = SW'(head_next) + SW'(AW'(lap_index));
        if (rd_sum >= SW'(LAP_DEPTH)) begin
            rd_addr = AW'(rd_sum - SW'(LAP_DEPTH));
        end else begin
            rd_addr = AW'(rd_sum);
        end
    end

    always_comb begin
        mem_ctl.wr_en  = step && lap_go;
        mem_ctl.rd_en  = step;
        mem_ctl.rd_hit = (ZW'(lap_index) < ZW'(total_next));
    end

    // State registers advance with each word handed to the result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg <= swls_pkg::RUN_IDLE;
            elapsed_reg   <= '0;
            total_reg     <= '0;
            head_reg      <= '0;
        end else if (step) begin
            run_state_reg <= run_state_next;
            elapsed_reg   <= elapsed_next;
            total_reg     <= total_next;
            head_reg      <= head_next;
        end
    end

endmodule

// ----- rtl/core/swls_checker.sv -----
// Port-level checker for the stopwatch with lap store, bound to the top level.
`include "stopwatch_with_lap_store_defines.svh"

module swls_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input swls_pkg::out_word_t m_data
);

    // A stalled result word keeps its valid and its contents.
    `SWL_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // With the result stage empty the input side always takes a word.
    `SWL_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input not ready with the result stage empty")

    // A lap is only stored while the stopwatch runs, and a lap never changes the run state.
    `SWL_ASSERT_NOW(a_lap_running, aclk, aresetn, m_valid && m_data.lap_taken, m_data.run_state == swls_pkg::RUN_ACTIVE, "lap stored while not running")

    // Idle is only reached through reset, so nothing has been counted or stored.
    `SWL_ASSERT_NOW(a_idle_clear, aclk, aresetn, m_valid && (m_data.run_state == swls_pkg::RUN_IDLE), (m_data.elapsed_ticks == '0) && (m_data.laps_held == '0) && (m_data.lap_value == '0), "idle with nonzero count or laps")

endmodule

bind stopwatch_with_lap_store swls_checker u_swls_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- test/stopwatch_with_lap_store_checker.sv -----
// Checker for the stopwatch with lap store: predicts each result word and compares it.
module stopwatch_with_lap_store_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  swls_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  swls_pkg::out_word_t m_data,
    output int                  mismatch_count,
    output int                  words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAP_SLOTS = swls_pkg::LAP_DEPTH_DEF;
    localparam int SLOT_W    = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;

    // Shadow copy of the stopwatch state.
    swls_pkg::run_state_t             watch_state;
    logic [swls_pkg::ELAPSED_W-1:0]   tick_total;
    logic [swls_pkg::HELD_W-1:0]      laps_stored;
    logic [swls_pkg::LAP_VALUE_W-1:0] lap_mem [LAP_SLOTS];

    // Snapshots still owed by the block, oldest first.
    swls_pkg::out_word_t snapshot_q [$];

    function void clear_watch();
        watch_state = swls_pkg::RUN_IDLE;
        tick_total  = '0;
        laps_stored = '0;
        for (int i = 0; i < LAP_SLOTS; i++) begin
            lap_mem[i] = '0;
        end
    endfunction

    // Apply one operation to the shadow state and return the snapshot after it.
    function swls_pkg::out_word_t apply_op(swls_pkg::in_word_t w);
        swls_pkg::out_word_t snap;
        logic                stored;
        stored = 1'b0;
        case (w.op)
            swls_pkg::OP_TICK: begin
                if (watch_state == swls_pkg::RUN_ACTIVE && tick_total != '1) begin
                    tick_total = tick_total + 1'b1;
                end
            end
            swls_pkg::OP_START: begin
                watch_state = swls_pkg::RUN_ACTIVE;
            end
            swls_pkg::OP_PAUSE: begin
                if (watch_state == swls_pkg::RUN_ACTIVE) begin
                    watch_state = swls_pkg::RUN_PAUSED;
                end
            end
            swls_pkg::OP_RESET: begin
                clear_watch();
            end
            swls_pkg::OP_LAP: begin
                // A full store drops its oldest entry and appends the new one last.
                if (watch_state == swls_pkg::RUN_ACTIVE) begin
                    stored = 1'b1;
                    if (laps_stored < LAP_SLOTS) begin
                        lap_mem[SLOT_W'(laps_stored)] = tick_total;
                        laps_stored = laps_stored + 1'b1;
                    end else begin
                        for (int i = 0; i < LAP_SLOTS - 1; i++) begin
                            lap_mem[i] = lap_mem[i + 1];
                        end
                        lap_mem[LAP_SLOTS - 1] = tick_total;
                    end
                end
            end
            default: begin
                // Read and the unused codes leave the state alone.
            end
        endcase
        snap.run_state     = watch_state;
        snap.elapsed_ticks = tick_total;
        snap.laps_held     = laps_stored;
        snap.lap_taken     = stored;
        snap.lap_value     = (w.lap_index < LAP_SLOTS && w.lap_index < laps_stored)
                             ? lap_mem[w.lap_index] : '0;
        return snap;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        mismatch_count = 0;
        words_pending  = 0;
        clear_watch();
    end

    // Compare outgoing words first, then predict for the incoming word of this edge.
    always @(posedge aclk) begin
        swls_pkg::out_word_t want;
        if (!aresetn) begin
            clear_watch();
            snapshot_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (snapshot_q.size() == 0) begin
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, m_data);
                    mismatch_count++;
                end else begin
                    want = snapshot_q.pop_front();
                    check_field("run_state", want.run_state, m_data.run_state);
                    check_field("elapsed_ticks", want.elapsed_ticks, m_data.elapsed_ticks);
                    check_field("laps_held", want.laps_held, m_data.laps_held);
                    check_field("lap_taken", want.lap_taken, m_data.lap_taken);
                    check_field("lap_value", want.lap_value, m_data.lap_value);
                end
            end
            if (s_valid && s_ready) begin
                snapshot_q.push_back(apply_op(s_data));
            end
        end
        words_pending = snapshot_q.size();
    end

endmodule

// ----- test/stopwatch_with_lap_store_tb.sv -----
// Testbench top for the stopwatch with lap store: clock, reset, stimulus and verdict.
module stopwatch_with_lap_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes outside the defined operation set; the block treats them as reads.
    localparam logic [swls_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [swls_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS   = 500;
    localparam int HOLD_CYCLES    = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PERCENT   = 7;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    swls_pkg::in_word_t  s_data;
    logic                m_valid;
    logic                m_ready;
    swls_pkg::out_word_t m_data;

    int mismatch_count;
    int words_pending;
    int cycle_count;
    bit gaps_on;
    bit hold_request;

    stopwatch_with_lap_store i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    stopwatch_with_lap_store_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // 8 ns clock.
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Give up if the run takes far longer than the slowest correct one.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("stopwatch_with_lap_store test failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= gaps_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
        end
    end

    // Offer one word at a falling edge and hold it until it is taken.
    task automatic send_op(logic [swls_pkg::OP_W-1:0] op,
                           logic [swls_pkg::INDEX_W-1:0] idx);
        swls_pkg::in_word_t w;
        w.op        = op;
        w.lap_index = idx;
        if (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Weighted choice that keeps the watch running most of the time.
    function automatic logic [swls_pkg::OP_W-1:0] pick_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)      return swls_pkg::OP_TICK;
        else if (roll < 60) return swls_pkg::OP_LAP;
        else if (roll < 70) return swls_pkg::OP_READ;
        else if (roll < 81) return swls_pkg::OP_START;
        else if (roll < 89) return swls_pkg::OP_PAUSE;
        else if (roll < 92) return swls_pkg::OP_RESET;
        else if (roll < 96) return OP_SPARE_LO;
        else                return OP_SPARE_HI;
    endfunction

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        gaps_on      = 1'b1;
        hold_request = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: ignored operations while idle, then the run and pause transitions.
        send_op(swls_pkg::OP_READ, 3'd0);
        send_op(swls_pkg::OP_TICK, 3'd7);
        send_op(swls_pkg::OP_PAUSE, 3'd0);
        send_op(swls_pkg::OP_LAP, 3'd0);
        send_op(swls_pkg::OP_START, 3'd0);
        send_op(swls_pkg::OP_TICK, 3'd0);
        send_op(swls_pkg::OP_START, 3'd0);
        send_op(swls_pkg::OP_LAP, 3'd0);
        send_op(swls_pkg::OP_PAUSE, 3'd0);
        send_op(swls_pkg::OP_LAP, 3'd1);
        send_op(swls_pkg::OP_TICK, 3'd0);
        send_op(swls_pkg::OP_START, 3'd0);
        send_op(OP_SPARE_LO, 3'd0);
        send_op(OP_SPARE_HI, 3'd7);
        send_op(swls_pkg::OP_RESET, 3'd0);
        send_op(swls_pkg::OP_START, 3'd7);

        // Fill the store, then one more lap to push out the oldest entry.
        for (int i = 0; i < swls_pkg::LAP_DEPTH_DEF; i++) begin
            send_op(swls_pkg::OP_LAP, 3'(i));
        end
        send_op(swls_pkg::OP_TICK, 3'd7);
        send_op(swls_pkg::OP_LAP, 3'd7);

        // Random operations, with a stretch of no gaps holding the long result stall.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            gaps_on = !(n >= 150 && n < 300);
            if (n == 200) begin
                hold_request = 1'b1;
            end
            send_op(pick_op(), 3'($urandom_range(7)));
        end
        s_valid <= 1'b0;
        gaps_on = 1'b1;

        // Drain everything still owed, then keep watching for stray words.
        while (words_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("stopwatch_with_lap_store test passed");
        end else begin
            $display("stopwatch_with_lap_store test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/swls_pkg.sv
rtl/core/swls_lap_mem.sv
rtl/core/swls_ctrl.sv
rtl/core/stopwatch_with_lap_store.sv
rtl/core/swls_checker.sv
test/stopwatch_with_lap_store_checker.sv
test/stopwatch_with_lap_store_tb.sv
